FILE: hw/rtl/bstm_pkg.sv
`default_nettype none

package bstm_pkg;

	// program characters
	localparam logic [7:0] CH_RIGHT = 8'h3E; // '>'
	localparam logic [7:0] CH_LEFT  = 8'h3C; // '<'
	localparam logic [7:0] CH_INC   = 8'h2B; // '+'
	localparam logic [7:0] CH_DEC   = 8'h2D; // '-'
	localparam logic [7:0] CH_OUT   = 8'h2E; // '.'
	localparam logic [7:0] CH_IN    = 8'h2C; // ','
	localparam logic [7:0] CH_OPEN  = 8'h5B; // '['
	localparam logic [7:0] CH_CLOSE = 8'h5D; // ']'

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam int DEPTH_BITS = 11;
	typedef logic [DEPTH_BITS-1:0] depth_t;

	typedef enum logic [1:0] {
		M_EXEC = 2'd0,
		M_FWD  = 2'd1,
		M_BACK = 2'd2,
		M_HALT = 2'd3
	} mode_t;

	typedef struct packed {
		logic       operation;
		logic [9:0] prog_addr;
		logic [7:0] prog_byte;
	} cmd_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_char;
		logic       halted;
		logic [9:0] program_counter;
	} res_t;

	// microcode steps
	typedef enum logic [1:0] {
		US_CLEAR = 2'd0,
		US_IDLE  = 2'd1,
		US_EXEC  = 2'd2,
		US_LOAD  = 2'd3
	} ustep_t;

	// jump conditions
	typedef enum logic [1:0] {
		J_CLR_DONE = 2'd0, // to target once the clearing pass ends
		J_DISPATCH = 2'd1, // on accept: step -> target, load -> target + 1
		J_OUT_FREE = 2'd2  // to target once the result register can load
	} jmp_t;

	typedef struct packed {
		logic   accept;
		logic   clear;
		logic   exec;
		logic   result;
		jmp_t   jmp;
		ustep_t target;
	} uword_t;

	localparam uword_t UCODE [4] = '{
		'{accept: 1'b0, clear: 1'b1, exec: 1'b0, result: 1'b0,
			jmp: J_CLR_DONE, target: US_IDLE},
		'{accept: 1'b1, clear: 1'b0, exec: 1'b0, result: 1'b0,
			jmp: J_DISPATCH, target: US_EXEC},
		'{accept: 1'b0, clear: 1'b0, exec: 1'b1, result: 1'b1,
			jmp: J_OUT_FREE, target: US_IDLE},
		'{accept: 1'b0, clear: 1'b0, exec: 1'b0, result: 1'b1,
			jmp: J_OUT_FREE, target: US_IDLE}
	};

endpackage

`default_nettype wire

FILE: hw/rtl/bstm_ram.sv
`default_nettype none

module bstm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bracket_scan_tape_machine_core.sv
// Tape machine for the eight-symbol bracket language.
//
// Command channel (cmd_valid / cmd_stall / cmd): each transaction either loads
// one program byte (operation = 0) or runs one machine iteration
// (operation = 1). Result channel (res_valid / res_stall / res): exactly one
// result transaction per command, in order.
//
// Timing: a command is taken in the dispatch step, where a load writes its byte.
// A step command's execute step uses the program byte and tape cell (registered
// RAM reads), writes the cell back and loads the result, valid on the next
// cycle; the load step only loads the result, then dispatch takes the next.
//
// Reset: arst_n clears control state and starts a clearing pass that zeroes
// the program store and the tape. cmd_stall stays high during the pass.
//
// Receiver stall: the result register holds its transaction; one more command
// is still taken and its execute or load step waits until the register frees.
`default_nettype none

module bracket_scan_tape_machine_core
	import bstm_pkg::*;
#(
	parameter int PROG_DEPTH = 1024,
	parameter int DATA_DEPTH = 65536,
	parameter int CELL_BITS  = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	localparam int PA        = $clog2(PROG_DEPTH);
	localparam int DA        = $clog2(DATA_DEPTH);
	localparam int CLR_DEPTH = (PROG_DEPTH > DATA_DEPTH) ? PROG_DEPTH : DATA_DEPTH;
	localparam int CW        = $clog2(CLR_DEPTH);

	// sequencer
	ustep_t upc_q, upc_d;
	uword_t uw;
	logic   cmd_acc, out_free, fire, exec_go, clr_done;

	// machine state
	logic [PA-1:0] pc_q, pc_d, pc_inc, pc_dec;
	logic [DA-1:0] dp_q, dp_d;
	depth_t        depth_q, depth_d;
	mode_t         mode_q, mode_d;
	logic [CW-1:0] clr_q;

	// memories
	logic                 prog_we, tape_we, tape_we_x;
	logic [PA-1:0]        prog_waddr;
	logic [7:0]           prog_wdata, prog_rdata;
	logic [DA-1:0]        tape_waddr;
	logic [CELL_BITS-1:0] tape_wdata, tape_wdata_x, tape_rdata;

	// result
	res_t res_q;
	logic res_full_q;
	logic ov;
	logic [7:0] oc;

	assign uw        = UCODE[upc_q];
	assign cmd_stall = !uw.accept;
	assign cmd_acc   = cmd_valid && uw.accept;
	assign out_free  = !res_full_q || !res_stall;
	assign fire      = uw.result && out_free;
	assign exec_go   = uw.exec && out_free;
	assign clr_done  = (clr_q == CW'(CLR_DEPTH - 1));

	always_comb begin
		upc_d = upc_q;
		case (uw.jmp)
			J_CLR_DONE: begin
				if (clr_done) upc_d = uw.target;
			end
			J_DISPATCH: begin
				if (cmd_acc) begin
					upc_d = (cmd.operation == OP_STEP) ? uw.target
						: ustep_t'(2'(uw.target) + 2'd1);
				end
			end
			J_OUT_FREE: begin
				if (out_free) upc_d = uw.target;
			end
			default: upc_d = uw.target;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= US_CLEAR;
		end else begin
			upc_q <= upc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (uw.clear && !clr_done) begin
			clr_q <= clr_q + CW'(1);
		end
	end

	// wrap-around moves
	assign pc_inc = (pc_q == PA'(PROG_DEPTH - 1)) ? '0 : pc_q + PA'(1);
	assign pc_dec = (pc_q == '0) ? PA'(PROG_DEPTH - 1) : pc_q - PA'(1);

	// one machine iteration on the registered program byte and cell
	always_comb begin
		pc_d         = pc_q;
		dp_d         = dp_q;
		depth_d      = depth_q;
		mode_d       = mode_q;
		tape_we_x    = 1'b0;
		tape_wdata_x = tape_rdata;
		ov           = 1'b0;
		oc           = 8'h00;
		if (exec_go) begin
			case (mode_q)
				M_EXEC: begin
					case (prog_rdata)
						CH_RIGHT: begin
							dp_d = (dp_q == DA'(DATA_DEPTH - 1)) ? '0 : dp_q + DA'(1);
							pc_d = pc_inc;
						end
						CH_LEFT: begin
							dp_d = (dp_q == '0) ? DA'(DATA_DEPTH - 1) : dp_q - DA'(1);
							pc_d = pc_inc;
						end
						CH_INC: begin
							tape_we_x    = 1'b1;
							tape_wdata_x = tape_rdata + CELL_BITS'(1);
							pc_d         = pc_inc;
						end
						CH_DEC: begin
							tape_we_x    = 1'b1;
							tape_wdata_x = tape_rdata - CELL_BITS'(1);
							pc_d         = pc_inc;
						end
						CH_OUT: begin
							ov   = 1'b1;
							oc   = tape_rdata[7:0];
							pc_d = pc_inc;
						end
						CH_IN: begin
							pc_d = pc_inc;
						end
						CH_OPEN: begin
							if (tape_rdata == '0) begin
								depth_d = depth_t'(1);
								mode_d  = M_FWD;
							end
							pc_d = pc_inc;
						end
						CH_CLOSE: begin
							depth_d = depth_t'(1);
							mode_d  = M_BACK;
							pc_d    = pc_dec;
						end
						default: mode_d = M_HALT;
					endcase
				end
				M_FWD: begin
					if (depth_q != '0) begin
						if (prog_rdata == CH_OPEN) depth_d = depth_q + depth_t'(1);
						else if (prog_rdata == CH_CLOSE) depth_d = depth_q - depth_t'(1);
						pc_d = pc_inc;
					end else begin
						mode_d = M_EXEC;
					end
				end
				M_BACK: begin
					if (depth_q != '0) begin
						if (prog_rdata == CH_OPEN) depth_d = depth_q - depth_t'(1);
						else if (prog_rdata == CH_CLOSE) depth_d = depth_q + depth_t'(1);
						pc_d = pc_dec;
					end else begin
						// land on the partner '[' and test it again
						pc_d   = pc_inc;
						mode_d = M_EXEC;
					end
				end
				default: ; // halted is sticky
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			dp_q    <= '0;
			depth_q <= '0;
			mode_q  <= M_EXEC;
		end else if (exec_go) begin
			pc_q    <= pc_d;
			dp_q    <= dp_d;
			depth_q <= depth_d;
			mode_q  <= mode_d;
		end
	end

	// RAM write ports: clearing pass or normal traffic
	always_comb begin
		if (uw.clear) begin
			prog_we    = (32'(clr_q) < PROG_DEPTH);
			prog_waddr = PA'(clr_q);
			prog_wdata = 8'h00;
			tape_we    = (32'(clr_q) < DATA_DEPTH);
			tape_waddr = DA'(clr_q);
			tape_wdata = '0;
		end else begin
			prog_we    = cmd_acc && (cmd.operation == OP_LOAD)
				&& (32'(cmd.prog_addr) < PROG_DEPTH);
			prog_waddr = PA'(cmd.prog_addr);
			prog_wdata = cmd.prog_byte;
			tape_we    = tape_we_x;
			tape_waddr = dp_q;
			tape_wdata = tape_wdata_x;
		end
	end

	bstm_ram #(
		.WIDTH(8),
		.DEPTH(PROG_DEPTH)
	) u_prog (
		.clk  (clk),
		.we   (prog_we),
		.waddr(prog_waddr),
		.wdata(prog_wdata),
		.raddr(pc_q),
		.rdata(prog_rdata)
	);

	bstm_ram #(
		.WIDTH(CELL_BITS),
		.DEPTH(DATA_DEPTH)
	) u_tape (
		.clk  (clk),
		.we   (tape_we),
		.waddr(tape_waddr),
		.wdata(tape_wdata),
		.raddr(dp_q),
		.rdata(tape_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_full_q <= 1'b0;
		end else if (fire) begin
			res_full_q <= 1'b1;
		end else if (!res_stall) begin
			res_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.out_valid       <= ov;
			res_q.out_char        <= oc;
			res_q.halted          <= (mode_d == M_HALT);
			res_q.program_counter <= 10'(pc_d);
		end
	end

	assign res_valid = res_full_q;
	assign res       = res_q;

	// checks
	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (upc_q == US_EXEC || upc_q == US_LOAD))
		else $error("accepted command not followed by execute or load step");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_HALT) |=> (mode_q == M_HALT))
		else $error("halted mode left");

	a_scan_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_EXEC ##1 (mode_q == M_FWD || mode_q == M_BACK)) |-> (depth_q == 1))
		else $error("scan entered with depth other than one");

	a_tape_write: assert property (@(posedge clk) disable iff (!arst_n)
		tape_we |-> (upc_q == US_CLEAR || upc_q == US_EXEC))
		else $error("tape written outside clear or execute step");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(upc_q == US_EXEC || upc_q == US_LOAD))
		else $error("result appeared without a result step");

endmodule

`default_nettype wire
